// ===== rtl/ppv_pkg.sv =====
package ppv_pkg;

    localparam int COORD_BITS    = 20;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int YAW_BITS      = 13;
    localparam int NEAR_BITS     = 17;
    localparam int SQ_BITS       = 2 * NEAR_BITS;
    localparam int S_DATA_RAW    = 2 * COORD_BITS + YAW_BITS + 1;
    localparam int S_DATA_BITS   = (S_DATA_RAW + 7) / 8 * 8;
    localparam int M_DATA_BITS   = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int TICK_BITS     = 17;
    localparam int CORDIC_STEPS  = 20;
    localparam int STEP_BITS     = 5;
    localparam int ISQRT_STEPS   = 16;
    localparam int DIV_STEPS     = 32;
    localparam int CV_BITS       = DIFF_BITS + 3;
    localparam int Z_BITS        = 24;
    localparam int ZABS_BITS     = 22;
    localparam int MRAD_BITS     = 12;

    localparam logic signed [Z_BITS-1:0] PI_URAD     = 24'sd3141593;
    localparam logic [ZABS_BITS-1:0]     HALF_MRAD   = 22'd500;
    localparam logic [22:0]              RECIP_1000  = 23'd4294968;
    localparam logic signed [14:0]       TURN_MRAD   = 15'sd6283;
    localparam logic signed [14:0]       HALF_TURN   = 15'sd3142;

    typedef enum logic [1:0] {
        MODE_POSE, MODE_POINT, MODE_TICK, MODE_EMPTY
    } mode_t;

    typedef enum logic [1:0] {
        KIND_TRACK, KIND_OBSTACLE, KIND_TIMEOUT
    } kind_t;

    typedef enum logic [2:0] {
        CFG_LOOKAHEAD, CFG_DECEL, CFG_STOP, CFG_MAX_LIN, CFG_MAX_ANG, CFG_TIMEOUT
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] lookahead_mm;
        logic [15:0] decel_mm;
        logic [15:0] stop_mm;
        logic [15:0] max_linear;
        logic [14:0] max_angular;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        kind_t                        kind;
        logic signed [DIFF_BITS-1:0]  dx;
        logic signed [DIFF_BITS-1:0]  dy;
        logic signed [YAW_BITS-1:0]   yaw;
    } job_t;

    typedef enum logic [1:0] {F_IDLE, F_SQ, F_CMP} front_state_t;

    typedef enum logic [3:0] {
        B_IDLE, B_SQ, B_CMP, B_ITER, B_ROUND, B_SCALE, B_WRAP, B_DIV, B_DONE
    } back_state_t;

    // atan(2^-i) in microradians
    function automatic logic [ZABS_BITS-1:0] atan_urad(input logic [STEP_BITS-1:0] i);
        logic [ZABS_BITS-1:0] v;
        unique case (i)
            5'd0:  v = 22'd785398;
            5'd1:  v = 22'd463648;
            5'd2:  v = 22'd244979;
            5'd3:  v = 22'd124355;
            5'd4:  v = 22'd62419;
            5'd5:  v = 22'd31240;
            5'd6:  v = 22'd15624;
            5'd7:  v = 22'd7812;
            5'd8:  v = 22'd3906;
            5'd9:  v = 22'd1953;
            5'd10: v = 22'd977;
            5'd11: v = 22'd488;
            5'd12: v = 22'd244;
            5'd13: v = 22'd122;
            5'd14: v = 22'd61;
            5'd15: v = 22'd31;
            5'd16: v = 22'd15;
            5'd17: v = 22'd8;
            5'd18: v = 22'd4;
            5'd19: v = 22'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ppv_front.sv =====
module ppv_front import ppv_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   s_tlast,
    input  cfg_t                   cfg,
    input  logic                   q_full,
    output logic                   q_push,
    output job_t                   q_job
);

    front_state_t state_reg, state_next;
    logic plan_active_reg, plan_active_next;
    logic [TICK_BITS-1:0] ticks_reg, ticks_next;
    logic signed [COORD_BITS-1:0] robot_x_reg, robot_x_next, robot_y_reg, robot_y_next;
    logic signed [YAW_BITS-1:0] yaw_reg, yaw_next;
    logic obst_reg, obst_next, found_reg, found_next;
    logic signed [COORD_BITS-1:0] carrot_x_reg, carrot_x_next, carrot_y_reg, carrot_y_next;
    logic signed [COORD_BITS-1:0] pt_x_reg, pt_x_next, pt_y_reg, pt_y_next;
    logic pt_last_reg, pt_last_next;
    logic signed [DIFF_BITS-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [SQ_BITS-1:0] sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic far_reg, far_next;
    logic [31:0] look2_reg, look2_next;

    logic signed [COORD_BITS-1:0] in_x, in_y, cx, cy;
    logic signed [YAW_BITS-1:0]   in_yaw;
    logic                         in_obst, accept, beyond;
    logic [TICK_BITS-1:0]         ticks_inc;
    logic [DIFF_BITS-1:0]         ax, ay;
    logic [NEAR_BITS-1:0]         ax_n, ay_n;
    logic [SQ_BITS:0]             dsq;

    assign in_x    = s_tdata[COORD_BITS-1:0];
    assign in_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_yaw  = s_tdata[2*COORD_BITS +: YAW_BITS];
    assign in_obst = s_tdata[2*COORD_BITS+YAW_BITS];

    assign s_tready = (state_reg == F_IDLE) && !q_full;
    assign accept   = s_tvalid && s_tready;

    assign ticks_inc = (ticks_reg != '1) ? ticks_reg + 1'b1 : ticks_reg;
    assign ax   = dx_reg[DIFF_BITS-1] ? DIFF_BITS'(-dx_reg) : DIFF_BITS'(dx_reg);
    assign ay   = dy_reg[DIFF_BITS-1] ? DIFF_BITS'(-dy_reg) : DIFF_BITS'(dy_reg);
    assign ax_n = NEAR_BITS'(ax);
    assign ay_n = NEAR_BITS'(ay);
    assign dsq  = (SQ_BITS+1)'(sqx_reg) + (SQ_BITS+1)'(sqy_reg);
    assign beyond = far_reg || (dsq > (SQ_BITS+1)'(look2_reg));
    assign cx = found_reg ? carrot_x_reg : pt_x_reg;
    assign cy = found_reg ? carrot_y_reg : pt_y_reg;

    always_comb begin
        state_next       = state_reg;
        plan_active_next = plan_active_reg;
        ticks_next       = ticks_reg;
        robot_x_next     = robot_x_reg;
        robot_y_next     = robot_y_reg;
        yaw_next         = yaw_reg;
        obst_next        = obst_reg;
        found_next       = found_reg;
        carrot_x_next    = carrot_x_reg;
        carrot_y_next    = carrot_y_reg;
        pt_x_next        = pt_x_reg;
        pt_y_next        = pt_y_reg;
        pt_last_next     = pt_last_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        sqx_next         = sqx_reg;
        sqy_next         = sqy_reg;
        far_next         = far_reg;
        look2_next       = look2_reg;
        q_push           = 1'b0;
        q_job.kind       = KIND_TIMEOUT;
        q_job.dx         = '0;
        q_job.dy         = '0;
        q_job.yaw        = yaw_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    unique case (mode_t'(s_tuser))
                        MODE_POSE: begin
                            robot_x_next     = in_x;
                            robot_y_next     = in_y;
                            yaw_next         = in_yaw;
                            obst_next        = in_obst;
                            plan_active_next = 1'b1;
                            ticks_next       = '0;
                            found_next       = 1'b0;
                        end
                        MODE_TICK: begin
                            ticks_next = ticks_inc;
                            if (plan_active_reg &&
                                ticks_inc > TICK_BITS'(cfg.timeout_ticks)) begin
                                plan_active_next = 1'b0;
                                q_push           = 1'b1;
                            end
                        end
                        MODE_EMPTY: plan_active_next = 1'b0;
                        MODE_POINT: begin
                            pt_x_next    = in_x;
                            pt_y_next    = in_y;
                            pt_last_next = s_tlast;
                            dx_next      = DIFF_BITS'(in_x) - DIFF_BITS'(robot_x_reg);
                            dy_next      = DIFF_BITS'(in_y) - DIFF_BITS'(robot_y_reg);
                            state_next   = F_SQ;
                        end
                    endcase
                end
            end
            F_SQ: begin
                far_next   = ((ax >> NEAR_BITS) != '0) || ((ay >> NEAR_BITS) != '0);
                sqx_next   = SQ_BITS'(ax_n) * SQ_BITS'(ax_n);
                sqy_next   = SQ_BITS'(ay_n) * SQ_BITS'(ay_n);
                look2_next = 32'(cfg.lookahead_mm) * 32'(cfg.lookahead_mm);
                state_next = F_CMP;
            end
            F_CMP: begin
                if (!found_reg && beyond) begin
                    carrot_x_next = pt_x_reg;
                    carrot_y_next = pt_y_reg;
                    found_next    = 1'b1;
                end
                if (pt_last_reg) begin
                    carrot_x_next = cx;
                    carrot_y_next = cy;
                    found_next    = 1'b0;
                    q_push        = 1'b1;
                    q_job.kind    = obst_reg ? KIND_OBSTACLE : KIND_TRACK;
                    q_job.dx      = DIFF_BITS'(cx) - DIFF_BITS'(robot_x_reg);
                    q_job.dy      = DIFF_BITS'(cy) - DIFF_BITS'(robot_y_reg);
                end
                state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= F_IDLE;
            plan_active_reg <= 1'b0;
            ticks_reg       <= '0;
            robot_x_reg     <= '0;
            robot_y_reg     <= '0;
            yaw_reg         <= '0;
            obst_reg        <= 1'b0;
            found_reg       <= 1'b0;
            carrot_x_reg    <= '0;
            carrot_y_reg    <= '0;
        end else begin
            state_reg       <= state_next;
            plan_active_reg <= plan_active_next;
            ticks_reg       <= ticks_next;
            robot_x_reg     <= robot_x_next;
            robot_y_reg     <= robot_y_next;
            yaw_reg         <= yaw_next;
            obst_reg        <= obst_next;
            found_reg       <= found_next;
            carrot_x_reg    <= carrot_x_next;
            carrot_y_reg    <= carrot_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        pt_x_reg    <= pt_x_next;
        pt_y_reg    <= pt_y_next;
        pt_last_reg <= pt_last_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        far_reg     <= far_next;
        look2_reg   <= look2_next;
    end

endmodule

// ===== rtl/ppv_queue.sv =====
module ppv_queue import ppv_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/ppv_back.sv =====
module ppv_back import ppv_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   q_empty,
    input  job_t                   q_job,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata,
    output logic [1:0]             m_tuser
);

    back_state_t state_reg, state_next;
    kind_t kind_reg, kind_next;
    logic signed [DIFF_BITS-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [YAW_BITS-1:0] yaw_reg, yaw_next;
    logic [SQ_BITS-1:0] sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic far_reg, far_next;
    logic [31:0] stop2_reg, stop2_next, decel2_reg, decel2_next;
    logic lin_zero_reg, lin_zero_next, lin_scale_reg, lin_scale_next;
    logic signed [CV_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [Z_BITS-1:0] z_reg, z_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic [31:0] iv_reg, iv_next, ir_reg, ir_next, ib_reg, ib_next;
    logic [ZABS_BITS-1:0] zabs_reg, zabs_next;
    logic zneg_reg, zneg_next;
    logic [31:0] mlin_reg, mlin_next;
    logic [MRAD_BITS-1:0] q1k_reg, q1k_next;
    logic signed [15:0] turn_reg, turn_next;
    logic [16:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_BITS-1:0] m_data_reg, m_data_next;
    logic [1:0] m_user_reg, m_user_next;

    logic [DIFF_BITS-1:0]      ax, ay;
    logic [NEAR_BITS-1:0]      ax_n, ay_n;
    logic [SQ_BITS:0]          dsq_near;
    logic [40:0]               dsq;
    logic signed [CV_BITS-1:0] xs, ys;
    logic [32:0]               isum;
    logic signed [Z_BITS-1:0]  zm, zs;
    logic [44:0]               rprod;
    logic signed [14:0]        bear, bw;
    logic signed [16:0]        turn2, lim;
    logic [16:0]               rem_sh;
    logic [15:0]               lin;
    logic                      out_free;

    assign ax   = dx_reg[DIFF_BITS-1] ? DIFF_BITS'(-dx_reg) : DIFF_BITS'(dx_reg);
    assign ay   = dy_reg[DIFF_BITS-1] ? DIFF_BITS'(-dy_reg) : DIFF_BITS'(dy_reg);
    assign ax_n = NEAR_BITS'(ax);
    assign ay_n = NEAR_BITS'(ay);
    assign dsq_near = (SQ_BITS+1)'(sqx_reg) + (SQ_BITS+1)'(sqy_reg);
    assign dsq  = far_reg ? (41'd1 << 40) : 41'(dsq_near);
    assign xs   = cx_reg >>> cnt_reg;
    assign ys   = cy_reg >>> cnt_reg;
    assign isum = 33'(ir_reg) + 33'(ib_reg);
    assign zm   = dx_reg[DIFF_BITS-1] ? PI_URAD - z_reg : z_reg;
    assign zs   = (dx_reg == '0 && dy_reg == '0) ? '0 : (dy_reg[DIFF_BITS-1] ? -zm : zm);
    assign rprod = 45'(zabs_reg) * 45'(RECIP_1000);
    assign bear = (zneg_reg ? -15'(signed'({1'b0, q1k_reg})) : 15'(signed'({1'b0, q1k_reg})))
                  - 15'(yaw_reg);
    assign bw   = (bear > HALF_TURN) ? bear - TURN_MRAD :
                  (bear < -HALF_TURN) ? bear + TURN_MRAD : bear;
    assign turn2 = 17'(bw) <<< 1;
    assign lim   = signed'({2'b00, cfg.max_angular});
    assign rem_sh = {rem_reg[15:0], quo_reg[31]};
    assign lin = lin_zero_reg ? 16'd0 : (lin_scale_reg ? quo_reg[15:0] : cfg.max_linear);
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        yaw_next       = yaw_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        far_next       = far_reg;
        stop2_next     = stop2_reg;
        decel2_next    = decel2_reg;
        lin_zero_next  = lin_zero_reg;
        lin_scale_next = lin_scale_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        z_next         = z_reg;
        cnt_next       = cnt_reg;
        iv_next        = iv_reg;
        ir_next        = ir_reg;
        ib_next        = ib_reg;
        zabs_next      = zabs_reg;
        zneg_next      = zneg_reg;
        mlin_next      = mlin_reg;
        q1k_next       = q1k_reg;
        turn_next      = turn_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    kind_next = q_job.kind;
                    dx_next   = q_job.dx;
                    dy_next   = q_job.dy;
                    yaw_next  = q_job.yaw;
                    if (q_job.kind != KIND_TRACK) begin
                        lin_zero_next  = 1'b1;
                        lin_scale_next = 1'b0;
                        turn_next      = '0;
                        state_next     = B_DONE;
                    end else begin
                        state_next = B_SQ;
                    end
                end
            end
            B_SQ: begin
                far_next    = ((ax >> NEAR_BITS) != '0) || ((ay >> NEAR_BITS) != '0);
                sqx_next    = SQ_BITS'(ax_n) * SQ_BITS'(ax_n);
                sqy_next    = SQ_BITS'(ay_n) * SQ_BITS'(ay_n);
                stop2_next  = 32'(cfg.stop_mm) * 32'(cfg.stop_mm);
                decel2_next = 32'(cfg.decel_mm) * 32'(cfg.decel_mm);
                cx_next     = CV_BITS'(signed'({1'b0, ax}));
                cy_next     = CV_BITS'(signed'({1'b0, ay}));
                z_next      = '0;
                state_next  = B_CMP;
            end
            B_CMP: begin
                lin_zero_next  = dsq < 41'(stop2_reg);
                lin_scale_next = !(dsq < 41'(stop2_reg)) && (dsq < 41'(decel2_reg));
                iv_next        = 32'(dsq);
                ir_next        = '0;
                ib_next        = 32'd1 << 30;
                cnt_next       = '0;
                state_next     = B_ITER;
            end
            B_ITER: begin
                // one CORDIC vectoring step and, while square-root digits remain, one root digit per cycle
                if (!cy_reg[CV_BITS-1]) begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    z_next  = z_reg + Z_BITS'(atan_urad(cnt_reg));
                end else begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    z_next  = z_reg - Z_BITS'(atan_urad(cnt_reg));
                end
                if (cnt_reg < STEP_BITS'(ISQRT_STEPS)) begin
                    if (33'(iv_reg) >= isum) begin
                        iv_next = iv_reg - 32'(isum);
                        ir_next = (ir_reg >> 1) + ib_reg;
                    end else begin
                        ir_next = ir_reg >> 1;
                    end
                    ib_next = ib_reg >> 2;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_BITS'(CORDIC_STEPS - 1)) begin
                    state_next = B_ROUND;
                end
            end
            B_ROUND: begin
                zneg_next  = zs[Z_BITS-1];
                zabs_next  = ZABS_BITS'(zs[Z_BITS-1] ? -zs : zs) + HALF_MRAD;
                mlin_next  = 32'(cfg.max_linear) * 32'(ir_reg[15:0]);
                state_next = B_SCALE;
            end
            B_SCALE: begin
                // divide by 1000 through a reciprocal, exact below 2^22
                q1k_next   = MRAD_BITS'(rprod >> 32);
                state_next = B_WRAP;
            end
            B_WRAP: begin
                if (turn2 > lim) begin
                    turn_next = 16'(lim);
                end else if (turn2 < -lim) begin
                    turn_next = 16'(-lim);
                end else begin
                    turn_next = 16'(turn2);
                end
                rem_next = '0;
                quo_next = mlin_reg;
                cnt_next = '0;
                state_next = lin_scale_reg ? B_DIV : B_DONE;
            end
            B_DIV: begin
                if (rem_sh >= {1'b0, cfg.decel_mm}) begin
                    rem_next = rem_sh - {1'b0, cfg.decel_mm};
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_BITS'(DIV_STEPS - 1)) begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {turn_reg, lin};
                    m_user_next   = kind_reg;
                    state_next    = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        yaw_reg       <= yaw_next;
        sqx_reg       <= sqx_next;
        sqy_reg       <= sqy_next;
        far_reg       <= far_next;
        stop2_reg     <= stop2_next;
        decel2_reg    <= decel2_next;
        lin_zero_reg  <= lin_zero_next;
        lin_scale_reg <= lin_scale_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        z_reg         <= z_next;
        cnt_reg       <= cnt_next;
        iv_reg        <= iv_next;
        ir_reg        <= ir_next;
        ib_reg        <= ib_next;
        zabs_reg      <= zabs_next;
        zneg_reg      <= zneg_next;
        mlin_reg      <= mlin_next;
        q1k_reg       <= q1k_next;
        turn_reg      <= turn_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

endmodule

// ===== rtl/pure_pursuit_velocity_command_core.sv =====
// Pure-pursuit velocity command core.
// Input stream s_*: s_tuser is the item mode (pose, path point, tick, empty plan),
// s_tlast marks the final point of a plan. Output stream m_*: one command per
// final point (tracking or obstacle stop) and per tick that times the plan out.
// Config channel cfg_*: index selects lookahead, decel, stop, max linear,
// max angular, timeout; always ready, write only while the core is idle.
// Front end takes pose, tick and empty-plan items straight from its idle state and
// path points through difference, squares and compare steps. Jobs go through a
// 2-entry queue to the command unit, which runs each tracking command through the
// 20-step CORDIC loop, followed by bit-serial division when the speed is scaled
// inside the deceleration zone. Obstacle and timeout commands go straight to the
// output state. Results sit in an output register; while the receiver stalls the
// front end keeps accepting items until the queue fills.
// Reset (aresetn low, synchronous) restores register defaults, clears the plan,
// the pose, the timer and any queued or pending command.
module pure_pursuit_velocity_command_core import ppv_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_DATA_BITS-1:0]   s_tdata,   // pos_x, pos_y, heading, obstacle
    input  logic [1:0]               s_tuser,   // mode
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_DATA_BITS-1:0]   m_tdata,   // linear_velocity, angular_velocity
    output logic [1:0]               m_tuser,   // kind
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_pop, q_full, q_empty;
    job_t push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOOKAHEAD: cfg_next.lookahead_mm  = cfg_data;
                CFG_DECEL:     cfg_next.decel_mm      = cfg_data;
                CFG_STOP:      cfg_next.stop_mm       = cfg_data;
                CFG_MAX_LIN:   cfg_next.max_linear    = cfg_data;
                CFG_MAX_ANG:   cfg_next.max_angular   = cfg_data[14:0];
                CFG_TIMEOUT:   cfg_next.timeout_ticks = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lookahead_mm  <= 16'd500;
            cfg_reg.decel_mm      <= 16'd1000;
            cfg_reg.stop_mm       <= 16'd300;
            cfg_reg.max_linear    <= 16'd300;
            cfg_reg.max_angular   <= 15'd1500;
            cfg_reg.timeout_ticks <= 16'd12;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ppv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    ppv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    ppv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ppv_pkg::*;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_DATA_BITS-1:0]   s_tdata;   // pos_x, pos_y, heading, obstacle
    logic [1:0]               s_tuser;   // mode
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_DATA_BITS-1:0]   m_tdata;   // linear_velocity, angular_velocity
    logic [1:0]               m_tuser;   // kind
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    pure_pursuit_velocity_command_core dut (.*);

    typedef struct packed {
        logic [15:0]        lin;
        logic signed [15:0] ang;
        kind_t              kind;
    } cmd_t;

    // predictor state
    logic [15:0] lookahead_r, decel_r, stop_r, max_lin_r, timeout_r;
    logic [14:0] max_ang_r;
    bit          plan_on, obst_on, carrot_hit;
    int unsigned tick_cnt;
    longint      rob_x, rob_y, rob_yaw, car_x, car_y;

    cmd_t cmd_q[$];
    int   fail_cnt;
    int   n_sent;
    bit   quiet_out;

    initial begin
        aclk = 0;
        forever begin
            #10 aclk = 1;
            #10 aclk = 0;
        end
    end

    initial begin
        #400ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint atan_mrad(longint dx, longint dy);
        longint x, y, z, xs, ys;
        longint tab[20] = '{785398, 463648, 244979, 124355, 62419, 31240, 15624,
                            7812, 3906, 1953, 977, 488, 244, 122, 61, 31, 15, 8, 4, 2};
        if (dx == 0 && dy == 0) return 0;
        x = dx < 0 ? -dx : dx;
        y = dy < 0 ? -dy : dy;
        z = 0;
        for (int i = 0; i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += tab[i];
            end else begin
                x -= ys; y += xs; z -= tab[i];
            end
        end
        if (dx < 0) z = 3141593 - z;
        if (dy < 0) z = -z;
        if (z >= 0) return (z + 500) / 1000;
        return -((-z + 500) / 1000);
    endfunction

    function automatic longint range_sq(longint dx, longint dy);
        longint ax, ay;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax >= 131072 || ay >= 131072) return 64'd1 << 40;
        return ax * ax + ay * ay;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r;
        r = 0;
        for (int b = 20; b >= 0; b--)
            if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v) r += 64'd1 << b;
        return r;
    endfunction

    // command the block should give for one item, if any
    function automatic bit predict_cmd(mode_t mode, longint px, longint py,
                                       longint yaw, bit obs, bit lst, output cmd_t c);
        longint dx, dy, dsq, lin, b, turn, lim;
        c = '0;
        case (mode)
            MODE_POSE: begin
                rob_x = px; rob_y = py; rob_yaw = yaw; obst_on = obs;
                plan_on = 1; tick_cnt = 0; carrot_hit = 0;
                return 0;
            end
            MODE_TICK: begin
                if (tick_cnt < 131071) tick_cnt++;
                if (plan_on && tick_cnt > timeout_r) begin
                    plan_on = 0;
                    c.kind = KIND_TIMEOUT;
                    return 1;
                end
                return 0;
            end
            MODE_EMPTY: begin
                plan_on = 0;
                return 0;
            end
            default: ;
        endcase
        if (!carrot_hit &&
            range_sq(px - rob_x, py - rob_y) > longint'(lookahead_r) * lookahead_r) begin
            car_x = px; car_y = py; carrot_hit = 1;
        end
        if (!lst) return 0;
        if (!carrot_hit) begin
            car_x = px; car_y = py;
        end
        carrot_hit = 0;
        if (obst_on) begin
            c.kind = KIND_OBSTACLE;
            return 1;
        end
        dx = car_x - rob_x;
        dy = car_y - rob_y;
        dsq = range_sq(dx, dy);
        if (dsq < longint'(stop_r) * stop_r) lin = 0;
        else if (dsq < longint'(decel_r) * decel_r)
            lin = longint'(max_lin_r) * floor_sqrt(dsq) / decel_r;
        else lin = max_lin_r;
        b = atan_mrad(dx, dy) - rob_yaw;
        while (b > 3142) b -= 6283;
        while (b < -3142) b += 6283;
        turn = 2 * b;
        lim = max_ang_r;
        if (turn > lim) turn = lim;
        if (turn < -lim) turn = -lim;
        c.lin = lin[15:0];
        c.ang = turn[15:0];
        c.kind = KIND_TRACK;
        return 1;
    endfunction

    // valid stays high across back-to-back items; drain() drops it
    task automatic send_item(mode_t mode, logic signed [19:0] px, logic signed [19:0] py,
                             logic signed [12:0] hd, bit obs, bit lst);
        cmd_t c;
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tlast  <= lst;
        s_tdata  <= {2'b0, obs, hd, py, px};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        if (predict_cmd(mode, px, py, hd, obs, lst, c)) cmd_q = {cmd_q, c};
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (cmd_q.size() != 0) @(posedge aclk);
        // a point or tick without a command may still be in flight
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            CFG_LOOKAHEAD: lookahead_r = val;
            CFG_DECEL:     decel_r = val;
            CFG_STOP:      stop_r = val;
            CFG_MAX_LIN:   max_lin_r = val;
            CFG_MAX_ANG:   max_ang_r = val[14:0];
            default:       timeout_r = val;
        endcase
        @(posedge aclk);
    endtask

    // result checker with random receiver stalls
    always @(posedge aclk) begin
        cmd_t exp_c;
        if (aresetn && m_tvalid && m_tready) begin
            if (cmd_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) $display("unexpected command %h kind %0d", m_tdata, m_tuser);
            end else begin
                exp_c = cmd_q.pop_front();
                if (m_tdata[15:0] !== exp_c.lin || m_tdata[31:16] !== exp_c.ang ||
                    m_tuser !== exp_c.kind) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch: exp lin %0d ang %0d kind %0d, got lin %0d ang %0d kind %0d",
                                 exp_c.lin, exp_c.ang, exp_c.kind, m_tdata[15:0],
                                 $signed(m_tdata[31:16]), m_tuser);
                end
            end
        end
        if (quiet_out) m_tready <= 1;
        else if ($urandom_range(0, 99) < 8) m_tready <= 0;
        else if (!m_tready && $urandom_range(0, 99) < 25) m_tready <= 1;
        else if ($urandom_range(0, 99) < 85) m_tready <= 1;
    end

    function automatic logic signed [19:0] near_coord(longint base, int span);
        return 20'(base + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_plan(int npts, int span, bit obs);
        logic signed [19:0] rx, ry;
        rx = $urandom_range(0, 3) == 0 ? 20'($urandom) : near_coord(0, 20000);
        ry = $urandom_range(0, 3) == 0 ? 20'($urandom) : near_coord(0, 20000);
        send_item(MODE_POSE, rx, ry, 13'($urandom), obs, 1'($urandom_range(0, 1)));
        for (int i = 0; i < npts; i++)
            send_item(MODE_POINT, near_coord(rx, span), near_coord(ry, span),
                      13'($urandom), 1'($urandom_range(0, 1)), i == npts - 1);
    endtask

    task automatic test_directed();
        send_item(MODE_POINT, 0, 0, 0, 0, 1);
        send_item(MODE_POSE, 0, 0, 0, 0, 0);
        send_item(MODE_POINT, 100, 0, 0, 0, 0);
        send_item(MODE_POINT, 700, 700, 0, 0, 0);
        send_item(MODE_POINT, -900, 50, 0, 0, 1);
        send_item(MODE_POSE, 1000, -1000, 13'sd3142, 0, 1);
        send_item(MODE_POINT, 1200, -1000, 0, 1, 1);
        send_item(MODE_POSE, -524288, -524288, -13'sd4096, 0, 0);
        send_item(MODE_POINT, 524287, 524287, 13'sd4095, 1, 1);
        send_item(MODE_POSE, 524287, 524287, 13'sd4095, 1, 0);
        send_item(MODE_POINT, 0, 0, 0, 0, 1);
        send_item(MODE_POSE, 0, 0, -13'sd3142, 0, 0);
        send_item(MODE_POINT, -5000, -1, 0, 0, 1);
        send_item(MODE_POINT, -5000, 0, 0, 0, 1);
        send_item(MODE_EMPTY, -1, -1, -1, 1, 1);
        for (int i = 0; i < 3; i++) send_item(MODE_TICK, -1, -1, -1, 1, 1);
        send_item(MODE_POSE, 0, 0, 0, 0, 0);
        for (int i = 0; i < 14; i++) send_item(MODE_TICK, 0, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_LOOKAHEAD, 0);
        write_reg(CFG_DECEL, 16'hFFFF);
        write_reg(CFG_STOP, 0);
        write_reg(CFG_MAX_LIN, 16'hFFFF);
        write_reg(CFG_MAX_ANG, 16'h7FFF);
        write_reg(CFG_TIMEOUT, 0);
        for (int i = 0; i < 6; i++) send_plan($urandom_range(1, 4), 70000, $urandom_range(0, 3) == 0);
        send_item(MODE_TICK, 0, 0, 0, 0, 0);
        send_item(MODE_TICK, 0, 0, 0, 0, 0);
        drain();
        write_reg(CFG_LOOKAHEAD, 16'hFFFF);
        write_reg(CFG_DECEL, 0);
        write_reg(CFG_STOP, 16'hFFFF);
        write_reg(CFG_MAX_LIN, 0);
        write_reg(CFG_MAX_ANG, 0);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_plan($urandom_range(1, 4), 70000, 0);
        drain();
    endtask

    task automatic test_random();
        int r;
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_LOOKAHEAD, 16'($urandom_range(0, 3000)));
            write_reg(CFG_DECEL, 16'($urandom_range(1, 4000)));
            write_reg(CFG_STOP, 16'($urandom_range(0, 800)));
            write_reg(CFG_MAX_LIN, 16'($urandom));
            write_reg(CFG_MAX_ANG, 16'($urandom_range(0, 7000)));
            write_reg(CFG_TIMEOUT, 16'($urandom_range(0, 6)));
            quiet_out = (ph == 2);
            while (n_sent < 130 * (ph + 1) + 60) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_plan($urandom_range(1, 5), $urandom_range(0, 1) ? 4000 : 150000,
                              $urandom_range(0, 5) == 0);
                else if (r < 90)
                    send_item(MODE_TICK, 20'($urandom), 20'($urandom), 13'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else if (r < 95)
                    send_item(MODE_EMPTY, 20'($urandom), 20'($urandom), 13'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                    send_item(MODE_POINT, 20'($urandom), 20'($urandom), 13'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            drain();
        end
    endtask

    initial begin
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 0;
        m_tready  = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data  = '0;
        fail_cnt  = 0;
        n_sent    = 0;
        quiet_out = 0;
        lookahead_r = 500; decel_r = 1000; stop_r = 300;
        max_lin_r = 300; max_ang_r = 1500; timeout_r = 12;
        plan_on = 0; obst_on = 0; carrot_hit = 0; tick_cnt = 0;
        rob_x = 0; rob_y = 0; rob_yaw = 0; car_x = 0; car_y = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_config_sweep();
        test_random();
        if (fail_cnt == 0 && cmd_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
